/* rtl/core/rdsg_pkg.sv */
// ----------------------------------------------------------------------------
// rdsg_pkg
// Shared types and constants for the ring/disc row span generator.
// ----------------------------------------------------------------------------
package rdsg_pkg;

    localparam logic [12:0] MAX_DIM       = 13'd4096;
    localparam logic [12:0] RST_WIDTH     = 13'd640;
    localparam logic [12:0] RST_HEIGHT    = 13'd480;
    localparam int          ROOT_BITS     = 12;

    localparam logic [1:0]  CFG_BUF_WIDTH  = 2'd0;
    localparam logic [1:0]  CFG_BUF_HEIGHT = 2'd1;

    // per-row control carried alongside the root cells
    typedef struct packed {
        logic               vis;
        logic               ring;
        logic [11:0]        sy;
        logic signed [13:0] cx;
    } t_side;

    // state of one digit-by-digit square root
    typedef struct packed {
        logic [23:0] rad;
        logic [13:0] rem;
        logic [11:0] root;
    } t_root;

endpackage

/* rtl/core/rdsg_prep.sv */
// ----------------------------------------------------------------------------
// rdsg_prep
// Front end: visibility tests, then r^2 - dy^2 as (r - dy) * (r + dy).
// ----------------------------------------------------------------------------
module rdsg_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [13:0]   i_center_x,
    input  logic signed [13:0]   i_center_y,
    input  logic [11:0]          i_outer_radius,
    input  logic [11:0]          i_inner_radius,
    input  logic signed [12:0]   i_row_offset,
    input  logic [12:0]          i_height,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rdsg_pkg::t_side      o_side,
    output rdsg_pkg::t_root      o_ro,
    output rdsg_pkg::t_root      o_ri
);

    logic                 r_s1_v;
    rdsg_pkg::t_side      r_s1_side;
    logic [11:0]          r_s1_od;
    logic [12:0]          r_s1_os;
    logic [11:0]          r_s1_id;
    logic [12:0]          r_s1_is;
    logic                 r_s2_v;
    rdsg_pkg::t_side      r_s2_side;
    logic [23:0]          r_s2_rad_o;
    logic [23:0]          r_s2_rad_i;

    logic                 w_rdy1;
    logic                 w_rdy2;
    logic [12:0]          w_ady;
    logic signed [14:0]   w_sy;
    logic                 w_on_screen;
    rdsg_pkg::t_side      n_s1_side;
    logic [24:0]          w_prod_o;
    logic [24:0]          w_prod_i;

    assign w_rdy2  = !r_s2_v || i_ready;
    assign w_rdy1  = !r_s1_v || w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        w_ady = i_row_offset[12] ? 13'(~i_row_offset + 13'sd1) : 13'(i_row_offset);
        w_sy  = 15'(i_center_y) + 15'(i_row_offset);
        w_on_screen = !w_sy[14] && (w_sy[13:0] < {1'b0, i_height});
        n_s1_side.vis  = (i_outer_radius != 12'd0) && (w_ady <= {1'b0, i_outer_radius})
                         && w_on_screen;
        n_s1_side.ring = (i_inner_radius != 12'd0) && (w_ady <= {1'b0, i_inner_radius});
        n_s1_side.sy   = w_sy[11:0];
        n_s1_side.cx   = i_center_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_side <= n_s1_side;
            r_s1_od   <= i_outer_radius - w_ady[11:0];
            r_s1_os   <= {1'b0, i_outer_radius} + w_ady;
            r_s1_id   <= i_inner_radius - w_ady[11:0];
            r_s1_is   <= {1'b0, i_inner_radius} + w_ady;
        end
    end

    assign w_prod_o = {13'd0, r_s1_od} * {12'd0, r_s1_os};
    assign w_prod_i = {13'd0, r_s1_id} * {12'd0, r_s1_is};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_s1_v) begin
            r_s2_side  <= r_s1_side;
            r_s2_rad_o <= w_prod_o[23:0];
            r_s2_rad_i <= w_prod_i[23:0];
        end
    end

    assign o_valid = r_s2_v;
    assign o_side  = r_s2_side;
    assign o_ro    = '{rad: r_s2_rad_o, rem: 14'd0, root: 12'd0};
    assign o_ri    = '{rad: r_s2_rad_i, rem: 14'd0, root: 12'd0};

endmodule

/* rtl/core/rdsg_cell.sv */
// ----------------------------------------------------------------------------
// rdsg_cell
// One root digit for the outer and inner square roots, then hand-off.
// ----------------------------------------------------------------------------
module rdsg_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rdsg_pkg::t_side  i_side,
    input  rdsg_pkg::t_root  i_ro,
    input  rdsg_pkg::t_root  i_ri,
    output logic             o_valid,
    input  logic             i_ready,
    output rdsg_pkg::t_side  o_side,
    output rdsg_pkg::t_root  o_ro,
    output rdsg_pkg::t_root  o_ri
);

    function automatic rdsg_pkg::t_root f_step(input rdsg_pkg::t_root a);
        rdsg_pkg::t_root res;
        logic [14:0]     rem_s;
        logic [14:0]     trial;
        res   = a;
        rem_s = {a.rem[12:0], a.rad[23:22]};
        trial = {1'b0, a.root, 2'b01};
        res.rad = {a.rad[21:0], 2'b00};
        if (rem_s >= trial) begin
            res.rem  = 14'(rem_s - trial);
            res.root = {a.root[10:0], 1'b1};
        end else begin
            res.rem  = rem_s[13:0];
            res.root = {a.root[10:0], 1'b0};
        end
        return res;
    endfunction

    logic             r_v;
    rdsg_pkg::t_side  r_side;
    rdsg_pkg::t_root  r_ro;
    rdsg_pkg::t_root  r_ri;
    logic             w_rdy;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_side <= i_side;
            r_ro   <= f_step(i_ro);
            r_ri   <= f_step(i_ri);
        end
    end

    assign o_valid = r_v;
    assign o_side  = r_side;
    assign o_ro    = r_ro;
    assign o_ri    = r_ri;

endmodule

/* rtl/core/rdsg_span.sv */
// ----------------------------------------------------------------------------
// rdsg_span
// Back end: span edges and clipping, then hole cut-out and result register.
// ----------------------------------------------------------------------------
module rdsg_span (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rdsg_pkg::t_side  i_side,
    input  logic [11:0]      i_oh,
    input  logic [11:0]      i_ih,
    input  logic [12:0]      i_width,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_row_visible,
    output logic [11:0]      o_screen_row,
    output logic             o_first_valid,
    output logic [12:0]      o_first_left,
    output logic [12:0]      o_first_right,
    output logic             o_second_valid,
    output logic [12:0]      o_second_left,
    output logic [12:0]      o_second_right
);

    logic                r_a_v;
    logic                r_a_vis;
    logic                r_a_ring;
    logic [11:0]         r_a_sy;
    logic signed [14:0]  r_a_l;
    logic signed [14:0]  r_a_rr;
    logic signed [14:0]  r_a_il;
    logic signed [14:0]  r_a_ir;

    logic                r_b_v;
    logic                r_b_vis;
    logic [11:0]         r_b_sy;
    logic                r_b_fv;
    logic [12:0]         r_b_fl;
    logic [12:0]         r_b_fr;
    logic                r_b_sv;
    logic [12:0]         r_b_sl;
    logic [12:0]         r_b_sr;

    logic                w_rdy_a;
    logic                w_rdy_b;
    logic signed [14:0]  w_cx;
    logic signed [14:0]  w_oh;
    logic signed [14:0]  w_ih;
    logic signed [14:0]  w_w;
    logic signed [14:0]  w_l_raw;
    logic signed [14:0]  w_rr_raw;
    logic signed [14:0]  w_lr;
    logic signed [14:0]  w_rl;
    logic signed [14:0]  w_f_end;
    logic                n_fv;
    logic                n_sv;

    assign w_rdy_b = !r_b_v || i_ready;
    assign w_rdy_a = !r_a_v || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_comb begin
        w_cx     = 15'(i_side.cx);
        w_oh     = $signed({3'b000, i_oh});
        w_ih     = $signed({3'b000, i_ih});
        w_w      = $signed({2'b00, i_width});
        w_l_raw  = w_cx - w_oh;
        w_rr_raw = w_cx + w_oh + 15'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a_vis  <= i_side.vis;
            r_a_ring <= i_side.ring;
            r_a_sy   <= i_side.sy;
            r_a_l    <= w_l_raw[14] ? 15'sd0 : w_l_raw;
            r_a_rr   <= (w_rr_raw > w_w) ? w_w : w_rr_raw;
            r_a_il   <= w_cx - w_ih;
            r_a_ir   <= w_cx + w_ih + 15'sd1;
        end
    end

    always_comb begin
        w_lr    = (r_a_il < r_a_rr) ? r_a_il : r_a_rr;
        w_rl    = (r_a_ir > r_a_l) ? r_a_ir : r_a_l;
        w_f_end = r_a_ring ? w_lr : r_a_rr;
        n_fv    = r_a_vis && (r_a_l < w_f_end);
        n_sv    = r_a_vis && r_a_ring && (w_rl < r_a_rr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_rdy_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_a_v) begin
            r_b_vis <= r_a_vis;
            r_b_sy  <= r_a_vis ? r_a_sy : 12'd0;
            r_b_fv  <= n_fv;
            r_b_fl  <= n_fv ? r_a_l[12:0] : 13'd0;
            r_b_fr  <= n_fv ? w_f_end[12:0] : 13'd0;
            r_b_sv  <= n_sv;
            r_b_sl  <= n_sv ? w_rl[12:0] : 13'd0;
            r_b_sr  <= n_sv ? r_a_rr[12:0] : 13'd0;
        end
    end

    assign o_valid        = r_b_v;
    assign o_row_visible  = r_b_vis;
    assign o_screen_row   = r_b_sy;
    assign o_first_valid  = r_b_fv;
    assign o_first_left   = r_b_fl;
    assign o_first_right  = r_b_fr;
    assign o_second_valid = r_b_sv;
    assign o_second_left  = r_b_sl;
    assign o_second_right = r_b_sr;

endmodule

/* rtl/core/ring_disc_row_span_generator.sv */
// ----------------------------------------------------------------------------
// ring_disc_row_span_generator
// Spans of one scanline of a filled disc or ring, with row and column clip.
//
// Input channel (i_valid/o_ready) transfers one row: center, outer and inner
// radius, row offset. Output channel (o_valid/i_ready) transfers one result:
// visible flag, screen row and up to two spans [left, right).
// Config channel (i_cfg_valid/o_cfg_ready, always ready) writes the buffer
// width (index 0) and height (index 1); write only while the block is idle.
// The pipeline has two front-end stages (tests, then the r^2 - dy^2
// multiply), a chain of 12 root cells that each settle one bit of both
// square roots, and two back-end stages for clipping and the result.
// Throughput is one row per cycle unless stalled; every stage holds its
// own valid bit. When the receiver stalls, the pipeline fills up bubble by
// bubble and o_ready drops only once all 16 stages hold a row; nothing is
// dropped. Reset empties the pipeline and sets width 640, height 480.
// ----------------------------------------------------------------------------
module ring_disc_row_span_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [13:0]  i_center_x,
    input  logic signed [13:0]  i_center_y,
    input  logic [11:0]         i_outer_radius,
    input  logic [11:0]         i_inner_radius,
    input  logic signed [12:0]  i_row_offset,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_row_visible,
    output logic [11:0]         o_screen_row,
    output logic                o_first_valid,
    output logic [12:0]         o_first_left,
    output logic [12:0]         o_first_right,
    output logic                o_second_valid,
    output logic [12:0]         o_second_left,
    output logic [12:0]         o_second_right
);

    localparam int NCELL = rdsg_pkg::ROOT_BITS;

    logic [12:0]      r_buffer_width;
    logic [12:0]      r_buffer_height;
    logic [12:0]      w_width;
    logic [12:0]      w_height;

    logic             w_v   [0:NCELL];
    logic             w_rdy [0:NCELL];
    rdsg_pkg::t_side  w_side[0:NCELL];
    rdsg_pkg::t_root  w_ro  [0:NCELL];
    rdsg_pkg::t_root  w_ri  [0:NCELL];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_width  <= rdsg_pkg::RST_WIDTH;
            r_buffer_height <= rdsg_pkg::RST_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rdsg_pkg::CFG_BUF_WIDTH:  r_buffer_width  <= i_cfg_data;
                rdsg_pkg::CFG_BUF_HEIGHT: r_buffer_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_width  = (r_buffer_width > rdsg_pkg::MAX_DIM) ? rdsg_pkg::MAX_DIM
                                                           : r_buffer_width;
    assign w_height = (r_buffer_height > rdsg_pkg::MAX_DIM) ? rdsg_pkg::MAX_DIM
                                                            : r_buffer_height;

    rdsg_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_outer_radius (i_outer_radius),
        .i_inner_radius (i_inner_radius),
        .i_row_offset   (i_row_offset),
        .i_height       (w_height),
        .o_valid        (w_v[0]),
        .i_ready        (w_rdy[0]),
        .o_side         (w_side[0]),
        .o_ro           (w_ro[0]),
        .o_ri           (w_ri[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rdsg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_side  (w_side[k]),
            .i_ro    (w_ro[k]),
            .i_ri    (w_ri[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_side  (w_side[k+1]),
            .o_ro    (w_ro[k+1]),
            .o_ri    (w_ri[k+1])
        );
    end

    rdsg_span u_span (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_v[NCELL]),
        .o_ready        (w_rdy[NCELL]),
        .i_side         (w_side[NCELL]),
        .i_oh           (w_ro[NCELL].root),
        .i_ih           (w_ri[NCELL].root),
        .i_width        (w_width),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_row_visible  (o_row_visible),
        .o_screen_row   (o_screen_row),
        .o_first_valid  (o_first_valid),
        .o_first_left   (o_first_left),
        .o_first_right  (o_first_right),
        .o_second_valid (o_second_valid),
        .o_second_left  (o_second_left),
        .o_second_right (o_second_right)
    );

endmodule
